>>> src/amc_pkg.sv
// shared types, constants and helpers for the affine matrix concat block
package amc_pkg;

   typedef logic signed [12:0] exp_type;

   typedef struct packed {
      logic        command;
      logic [1:0]  row_index;
      logic [31:0] elem0;
      logic [31:0] elem1;
      logic [31:0] elem2;
      logic [31:0] elem3;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_row;
      logic [31:0] out_col0;
      logic [31:0] out_col1;
      logic [31:0] out_col2;
      logic [31:0] out_col3;
   } rsp_type;

   localparam logic        CMD_LOAD  = 1'b0;
   localparam logic        CMD_MUL   = 1'b1;
   localparam logic [1:0]  ROW_NONE  = 2'd3;
   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
   localparam logic [31:0] ZERO_BITS = 32'h0000_0000;
   localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;
   localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
   localparam int unsigned FMA_LAT   = 6;
   localparam int unsigned LANE_LAT  = 4 * FMA_LAT;

   function automatic logic [5:0] top_bit(input logic [63:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            n = 6'(i);
         end
      end
      return n;
   endfunction

endpackage

>>> src/amc_fma.sv
// pipelined single-precision fused multiply-add, round to nearest even
module amc_fma (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] x,
   input  logic [31:0] y,
   input  logic [31:0] z,
   output logic [31:0] r
);
   import amc_pkg::*;

   // stage 1: unpack, multiply, special cases
   logic [7:0]  xe, ye, ze;
   logic [23:0] xs, ys, zs;
   logic        xnan, ynan, znan, xinf, yinf, zinf, xzero, yzero, zzero, ps;
   logic        spec1;
   logic [31:0] specv1;

   logic [47:0] sp1_ff;
   exp_type     ep1_ff, ez1_ff;
   logic [23:0] mz1_ff;
   logic        ps1_ff, zsg1_ff, zz1_ff, spec1_ff;
   logic [31:0] specv1_ff;

   always_comb begin
      xe = x[30:23];
      ye = y[30:23];
      ze = z[30:23];
      xs = {(xe != 8'd0), x[22:0]};
      ys = {(ye != 8'd0), y[22:0]};
      zs = {(ze != 8'd0), z[22:0]};
      xnan = (xe == 8'hFF) && (x[22:0] != 23'd0);
      ynan = (ye == 8'hFF) && (y[22:0] != 23'd0);
      znan = (ze == 8'hFF) && (z[22:0] != 23'd0);
      xinf = (xe == 8'hFF) && (x[22:0] == 23'd0);
      yinf = (ye == 8'hFF) && (y[22:0] == 23'd0);
      zinf = (ze == 8'hFF) && (z[22:0] == 23'd0);
      xzero = (x[30:0] == 31'd0);
      yzero = (y[30:0] == 31'd0);
      zzero = (z[30:0] == 31'd0);
      ps = x[31] ^ y[31];
      spec1 = 1'b1;
      specv1 = QNAN_BITS;
      if (xnan || ynan || znan) begin
         specv1 = QNAN_BITS;
      end else if ((xinf || yinf) && (xzero || yzero)) begin
         specv1 = QNAN_BITS;
      end else if (xinf || yinf) begin
         specv1 = (zinf && (z[31] != ps)) ? QNAN_BITS : {ps, INF_BITS[30:0]};
      end else if (zinf) begin
         specv1 = z;
      end else if (xzero || yzero) begin
         specv1 = zzero ? {ps & z[31], 31'd0} : z;
      end else begin
         spec1 = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sp1_ff    <= xs * ys;
         ep1_ff    <= exp_type'({5'd0, (xe == 8'd0) ? 8'd1 : xe})
                    + exp_type'({5'd0, (ye == 8'd0) ? 8'd1 : ye}) - exp_type'(300);
         ez1_ff    <= exp_type'({5'd0, (ze == 8'd0) ? 8'd1 : ze}) - exp_type'(150);
         mz1_ff    <= zs;
         ps1_ff    <= ps;
         zsg1_ff   <= z[31];
         zz1_ff    <= zzero;
         spec1_ff  <= spec1;
         specv1_ff <= specv1;
      end
   end

   // stage 2: normalize both operands to bit 62
   logic [5:0]  lp, lz;
   logic [6:0]  shp, shz;
   logic [63:0] mp2_ff, mz2_ff;
   exp_type     ep2_ff, ez2_ff;
   logic        ps2_ff, zsg2_ff, zz2_ff, spec2_ff;
   logic [31:0] specv2_ff;

   always_comb begin
      lp  = top_bit({16'd0, sp1_ff});
      lz  = top_bit({40'd0, mz1_ff});
      shp = 7'd62 - {1'b0, lp};
      shz = 7'd62 - {1'b0, lz};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mp2_ff    <= {16'd0, sp1_ff} << shp;
         mz2_ff    <= {40'd0, mz1_ff} << shz;
         ep2_ff    <= ep1_ff - exp_type'({6'd0, shp});
         ez2_ff    <= ez1_ff - exp_type'({6'd0, shz});
         ps2_ff    <= ps1_ff;
         zsg2_ff   <= zsg1_ff;
         zz2_ff    <= zz1_ff;
         spec2_ff  <= spec1_ff;
         specv2_ff <= specv1_ff;
      end
   end

   // stage 3: order by magnitude and align the smaller with sticky
   logic        pbig;
   logic [63:0] big, lesser;
   exp_type     eb, dd;
   logic [6:0]  dc;
   logic [127:0] sh;
   logic [63:0] big3_ff, small3_ff;
   exp_type     eb3_ff;
   logic        sb3_ff, sub3_ff, spec3_ff;
   logic [31:0] specv3_ff;

   always_comb begin
      pbig = zz2_ff || (ep2_ff > ez2_ff) || ((ep2_ff == ez2_ff) && (mp2_ff >= mz2_ff));
      big    = pbig ? mp2_ff : mz2_ff;
      lesser = pbig ? mz2_ff : mp2_ff;
      eb     = pbig ? ep2_ff : ez2_ff;
      dd     = pbig ? (ep2_ff - ez2_ff) : (ez2_ff - ep2_ff);
      dc     = (dd > exp_type'(64)) ? 7'd64 : dd[6:0];
      sh     = {lesser, 64'd0} >> dc;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         big3_ff   <= big;
         small3_ff <= zz2_ff ? 64'd0 : (sh[127:64] | {63'd0, (sh[63:0] != 64'd0)});
         eb3_ff    <= eb;
         sb3_ff    <= pbig ? ps2_ff : zsg2_ff;
         sub3_ff   <= ps2_ff ^ zsg2_ff;
         spec3_ff  <= spec2_ff;
         specv3_ff <= specv2_ff;
      end
   end

   // stage 4: add or subtract
   logic [63:0] m4_ff;
   exp_type     e4_ff;
   logic        sb4_ff, spec4_ff;
   logic [31:0] specv4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m4_ff  <= sub3_ff ? (big3_ff - small3_ff) : (big3_ff + small3_ff);
         e4_ff  <= eb3_ff;
         sb4_ff <= sb3_ff;
         if (!spec3_ff && sub3_ff && (big3_ff == small3_ff)) begin
            spec4_ff  <= 1'b1;
            specv4_ff <= ZERO_BITS;
         end else begin
            spec4_ff  <= spec3_ff;
            specv4_ff <= specv3_ff;
         end
      end
   end

   // stage 5: leading one and rounding position
   logic [5:0]  lead;
   exp_type     s1, s2, s;
   logic [63:0] m5_ff;
   exp_type     s5_ff, se5_ff;
   logic        sb5_ff, spec5_ff;
   logic [31:0] specv5_ff;

   always_comb begin
      lead = top_bit(m4_ff);
      s1 = exp_type'({7'd0, lead}) - exp_type'(23);
      s2 = exp_type'(-149) - e4_ff;
      s  = (s1 > s2) ? s1 : s2;
      if (s > exp_type'(65)) begin
         s = exp_type'(65);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m5_ff     <= m4_ff;
         s5_ff     <= s;
         se5_ff    <= e4_ff + s;
         sb5_ff    <= sb4_ff;
         spec5_ff  <= spec4_ff;
         specv5_ff <= specv4_ff;
      end
   end

   // stage 6: shift, round and pack
   logic [127:0] rsh;
   logic [63:0]  lsh;
   logic [24:0]  q;
   exp_type      se, nsub;
   exp_type      biased;
   logic [31:0]  res;
   logic [31:0]  r_ff;

   always_comb begin
      nsub = -s5_ff;
      rsh  = {m5_ff, 64'd0} >> s5_ff[6:0];
      lsh  = m5_ff << nsub[4:0];
      se   = se5_ff;
      if (s5_ff <= exp_type'(0)) begin
         q = lsh[24:0];
      end else begin
         q = rsh[88:64] + {24'd0, rsh[63] & ((rsh[62:0] != 63'd0) | rsh[64])};
      end
      if (q[24]) begin
         q  = q >> 1;
         se = se + exp_type'(1);
      end
      biased = se + exp_type'(150);
      if (q[23]) begin
         if (biased >= exp_type'(255)) begin
            res = {sb5_ff, INF_BITS[30:0]};
         end else begin
            res = {sb5_ff, biased[7:0], q[22:0]};
         end
      end else begin
         res = {sb5_ff, 8'd0, q[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= spec5_ff ? specv5_ff : res;
      end
   end

   assign r = r_ff;

endmodule

>>> src/amc_lane.sv
// one product column: a chain of fused multiply-adds with operand delay lines
module amc_lane #(
   parameter int unsigned Col = 0
) (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] b0,
   input  logic [31:0] b1,
   input  logic [31:0] b2,
   input  logic [31:0] a0,
   input  logic [31:0] a1,
   input  logic [31:0] a2,
   input  logic [31:0] a3,
   output logic [31:0] result
);
   import amc_pkg::*;

   localparam int unsigned Depth = 3 * FMA_LAT;

   typedef struct packed {
      logic [31:0] a1;
      logic [31:0] a2;
      logic [31:0] a3;
      logic [31:0] b1;
      logic [31:0] b2;
   } opnd_type;

   opnd_type    line_ff [Depth];
   logic [31:0] t0, t1, t2;

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= '{a1: a1, a2: a2, a3: a3, b1: b1, b2: b2};
         for (int i = 1; i < Depth; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   amc_fma u_fma0 (.clock(clock), .en(en), .x(b0), .y(a0), .z(NEG_ZERO), .r(t0));
   amc_fma u_fma1 (.clock(clock), .en(en), .x(line_ff[FMA_LAT-1].b1),
                   .y(line_ff[FMA_LAT-1].a1), .z(t0), .r(t1));
   amc_fma u_fma2 (.clock(clock), .en(en), .x(line_ff[2*FMA_LAT-1].b2),
                   .y(line_ff[2*FMA_LAT-1].a2), .z(t1), .r(t2));

   generate
      if (Col >= 2) begin : g_a3
         amc_fma u_fma3 (.clock(clock), .en(en), .x((Col == 3) ? ONE_BITS : ZERO_BITS),
                         .y(line_ff[Depth-1].a3), .z(t2), .r(result));
      end else begin : g_pass
         logic [31:0] pass_ff [FMA_LAT];
         always_ff @(posedge clock) begin
            if (en) begin
               pass_ff[0] <= t2;
               for (int i = 1; i < FMA_LAT; i++) begin
                  pass_ff[i] <= pass_ff[i-1];
               end
            end
         end
         assign result = pass_ff[FMA_LAT-1];
      end
   endgenerate

endmodule

>>> src/affine_matrix_concat_fma.sv
// top level: right-matrix store, four column lanes and the result register
// a multiply transfer passes through the lane pipeline and then the result register to rsp_valid
// throughput: one item per cycle; the whole 24-stage lane pipeline advances together
// and holds while a result waits under rsp_stall
// reset clears the valid bits of the pipeline and the result register only;
// the right-hand matrix is undefined until its rows are loaded
module affine_matrix_concat_fma (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  amc_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output amc_pkg::rsp_type  rsp_payload
);
   import amc_pkg::*;

   logic [31:0] b_ff [12];
   logic        vld_ff [LANE_LAT];
   logic [1:0]  row_ff [LANE_LAT];
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic        adv, take, mul_in;
   logic [31:0] col [4];

   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign take    = req_valid && adv;
   assign mul_in  = take && (req_payload.command == CMD_MUL)
                    && (req_payload.row_index != ROW_NONE);

   always_ff @(posedge clock) begin
      if (take && (req_payload.command == CMD_LOAD)
          && (req_payload.row_index != ROW_NONE)) begin
         b_ff[{req_payload.row_index, 2'd0}] <= req_payload.elem0;
         b_ff[{req_payload.row_index, 2'd1}] <= req_payload.elem1;
         b_ff[{req_payload.row_index, 2'd2}] <= req_payload.elem2;
         b_ff[{req_payload.row_index, 2'd3}] <= req_payload.elem3;
      end
   end

   generate
      for (genvar c = 0; c < 4; c++) begin : g_lane
         amc_lane #(.Col(c)) u_lane (
            .clock (clock),
            .en    (adv),
            .b0    (b_ff[c]),
            .b1    (b_ff[4+c]),
            .b2    (b_ff[8+c]),
            .a0    (req_payload.elem0),
            .a1    (req_payload.elem1),
            .a2    (req_payload.elem2),
            .a3    (req_payload.elem3),
            .result(col[c])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= mul_in;
         for (int i = 1; i < LANE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         row_ff[0] <= req_payload.row_index;
         for (int i = 1; i < LANE_LAT; i++) begin
            row_ff[i] <= row_ff[i-1];
         end
         rsp_ff <= '{out_row: row_ff[LANE_LAT-1], out_col0: col[0], out_col1: col[1],
                     out_col2: col[2], out_col3: col[3]};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_stall_only_when_full: assert property (@(posedge clock)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (take && (req_payload.command == CMD_LOAD)) |=> !vld_ff[0])
      else $error("load transfer entered the result pipeline");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
